>>> sv/mrtu_pkg.sv
// Shared types and constants for the Modbus RTU slave frame engine.
// Depends on nothing; every module of the block imports it.
package mrtu_pkg;

	localparam int FRAME_BYTES = 64;
	localparam int ADDR_W = $clog2(FRAME_BYTES);
	localparam int LEN_W = ADDR_W + 1;
	localparam int HDR_BYTES = 8;
	localparam int HOLD_REGS = 7;
	localparam int MAX_READ_REGS = 29;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [7:0] STATION_RESET = 8'd1;

	localparam logic [7:0] FN_READ_HOLD = 8'h03;
	localparam logic [7:0] FN_READ_INPUT = 8'h04;
	localparam logic [7:0] FN_WRITE_ONE = 8'h06;
	localparam logic [7:0] FN_WRITE_MANY = 8'h10;

	typedef enum logic [2:0] {
		ST_RX,
		ST_RXCRC,
		ST_CHECK,
		ST_WRRD,
		ST_WRUP,
		ST_GEN,
		ST_TXCRC
	} state_t;

	typedef struct packed {
		logic init;
		logic xor_en;
		logic step;
	} crc_ctl_t;

endpackage

>>> sv/modbus_rtu_slave_frame_engine.sv
// Modbus RTU slave frame engine: frame store, checks, register file, reply.
// Depends on mrtu_pkg and mrtu_crc_serial.
//
// Usage: received bytes enter on the request channel (in_valid/in_stall) with
// frame_end high on the last byte of a frame. Each stored byte is accepted in
// ST_RX and then folded into the bit-serial CRC in ST_RXCRC; in_stall is high
// meanwhile. After a stored frame_end byte the frame is checked (length, CRC,
// station address, function) in ST_CHECK, which waits until the final byte of
// the previous reply has been taken so that the settings outputs stay steady.
// A function 16 request then writes its registers one at a time, each as a
// frame store read then an update. Reply bytes leave on the result channel
// (out_valid/out_stall). A byte that feeds the reply CRC runs the bit-serial
// CRC in ST_TXCRC; echoed and CRC bytes go one per cycle while out_stall is
// low. A held result does not stop the engine from loading the next one once
// it is taken. A stalled result holds its value. The next frame byte is
// accepted once the final reply byte is loaded into the output register.
// Reset clears the frame length, overflow flag, holding registers and the
// station address (to 1); the frame store needs no clearing.
// station_address is written over cfg_valid/cfg_data; cfg_ready is always high.
module modbus_rtu_slave_frame_engine (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       frame_end,
	input  logic [7:0] alarm_flags,
	input  logic [7:0] signal_flags,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] reply_byte,
	output logic       reply_last,
	output logic       settings_changed,
	output logic [7:0] channel_setting,
	output logic [7:0] sync_setting,
	output logic [7:0] fan_setting,
	output logic [7:0] power_setting,
	output logic [7:0] alarm_temp_setting,
	output logic [7:0] mode_setting,
	output logic [7:0] main_switch_setting,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);
	import mrtu_pkg::*;

	state_t            state_q, state_d;
	logic [7:0]        mem_q [FRAME_BYTES];
	logic [7:0]        rd_data_q;
	logic [ADDR_W-1:0] rd_addr;
	logic [LEN_W-1:0]  len_q;
	logic              ovf_q, end_q, chg_q;
	logic [7:0]        alarm_q, sig_q, station_q;
	logic [7:0]        hdr_q [HDR_BYTES];
	logic [7:0]        hold_q [HOLD_REGS];
	logic [6:0]        rn_q, k_q;
	logic [4:0]        i_q;
	logic [2:0]        bit_q;
	logic              out_valid_q, reply_last_q;
	logic [7:0]        reply_byte_q;

	crc_ctl_t          crc_ctl;
	logic [15:0]       crc;
	logic [7:0]        crc_data;

	logic              in_acc, room, slot_free, last_k;
	logic [15:0]       start, cnt;
	logic              base_ok, rd_ok, w1_ok, wm_ok;
	logic [16:0]       a_wr, a_rd;
	logic [6:0]        j;
	logic [7:0]        gen_byte, rd_val;
	logic              gen_plain;

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != ST_RX);
	assign in_acc = in_valid && !in_stall;
	assign room = (len_q < LEN_W'(FRAME_BYTES));
	assign slot_free = !out_valid_q || !out_stall;
	assign last_k = (k_q == rn_q - 7'd1);

	assign start = {hdr_q[2], hdr_q[3]};
	assign cnt = {hdr_q[4], hdr_q[5]};

	// Frame checks
	assign base_ok = (len_q >= LEN_W'(4)) && (crc == 16'h0000) && (hdr_q[0] == station_q);
	assign rd_ok = (len_q == LEN_W'(8)) && (cnt != 16'd0) && (cnt <= 16'(MAX_READ_REGS));
	assign w1_ok = (len_q == LEN_W'(8));
	assign wm_ok = (len_q >= LEN_W'(9)) && (cnt != 16'd0)
		&& ({9'd0, hdr_q[6]} == {1'b0, cnt} + {1'b0, cnt})
		&& ({10'd0, len_q} == 17'd9 + {1'b0, cnt} + {1'b0, cnt});

	assign a_wr = {1'b0, start} + {12'd0, i_q};
	assign j = k_q - 7'd3;
	assign a_rd = {1'b0, start} + {11'd0, j[6:1]};
	assign rd_addr = ADDR_W'(7'd8 + {1'b0, i_q, 1'b0});

	// Register value for a read reply word
	always_comb begin
		rd_val = 8'h00;
		if (hdr_q[1] == FN_READ_HOLD) begin
			if (a_rd < 17'(HOLD_REGS)) rd_val = hold_q[a_rd[2:0]];
		end else begin
			if (a_rd == 17'd0) rd_val = alarm_q;
			else if (a_rd == 17'd1) rd_val = sig_q;
		end
	end

	// Pick the next reply byte; gen_plain marks bytes that skip the CRC update
	always_comb begin
		gen_byte = 8'h00;
		gen_plain = 1'b1;
		case (hdr_q[1])
			FN_WRITE_ONE: begin
				gen_byte = hdr_q[k_q[2:0]];
			end
			FN_WRITE_MANY: begin
				if (k_q < 7'd6) begin
					gen_byte = hdr_q[k_q[2:0]];
					gen_plain = 1'b0;
				end else if (k_q == 7'd6) begin
					gen_byte = crc[7:0];
				end else begin
					gen_byte = crc[15:8];
				end
			end
			default: begin
				gen_plain = 1'b0;
				if (k_q < 7'd2) begin
					gen_byte = hdr_q[k_q[2:0]];
				end else if (k_q == 7'd2) begin
					gen_byte = {cnt[6:0], 1'b0};
				end else if (k_q == rn_q - 7'd2) begin
					gen_byte = crc[7:0];
					gen_plain = 1'b1;
				end else if (k_q == rn_q - 7'd1) begin
					gen_byte = crc[15:8];
					gen_plain = 1'b1;
				end else begin
					gen_byte = j[0] ? rd_val : 8'h00;
				end
			end
		endcase
	end

	// Next state and CRC control
	always_comb begin
		state_d = state_q;
		crc_ctl = '0;
		crc_data = rx_byte;
		unique case (state_q)
			ST_RX: begin
				if (in_acc) begin
					if (room) begin
						crc_ctl.xor_en = 1'b1;
						state_d = ST_RXCRC;
					end else if (frame_end) begin
						crc_ctl.init = 1'b1;
					end
				end
			end
			ST_RXCRC: begin
				crc_ctl.step = 1'b1;
				if (bit_q == 3'd7) state_d = end_q ? ST_CHECK : ST_RX;
			end
			ST_CHECK: begin
				// wait for the previous reply to drain
				if (!out_valid_q) begin
					crc_ctl.init = 1'b1;
					state_d = ST_RX;
					if (base_ok) begin
						if ((hdr_q[1] == FN_READ_HOLD || hdr_q[1] == FN_READ_INPUT) && rd_ok)
							state_d = ST_GEN;
						else if (hdr_q[1] == FN_WRITE_ONE && w1_ok)
							state_d = ST_GEN;
						else if (hdr_q[1] == FN_WRITE_MANY && wm_ok)
							state_d = ST_WRRD;
					end
				end
			end
			ST_WRRD: begin
				state_d = ST_WRUP;
			end
			ST_WRUP: begin
				if ({11'd0, i_q} + 16'd1 == cnt) state_d = ST_GEN;
				else state_d = ST_WRRD;
			end
			ST_GEN: begin
				crc_data = gen_byte;
				if (slot_free) begin
					if (gen_plain) begin
						if (last_k) begin
							crc_ctl.init = 1'b1;
							state_d = ST_RX;
						end
					end else begin
						crc_ctl.xor_en = 1'b1;
						state_d = ST_TXCRC;
					end
				end
			end
			ST_TXCRC: begin
				crc_ctl.step = 1'b1;
				if (bit_q == 3'd7) state_d = ST_GEN;
			end
			default: state_d = ST_RX;
		endcase
	end

	mrtu_crc_serial u_crc (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (crc_ctl),
		.data_in (crc_data),
		.crc     (crc)
	);

	// Hold the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_RX;
		else state_q <= state_d;
	end

	// Store frame bytes and read data bytes back for multi-register writes
	always_ff @(posedge clk) begin
		if (in_acc && room) mem_q[len_q[ADDR_W-1:0]] <= rx_byte;
		rd_data_q <= mem_q[rd_addr];
	end

	// Keep the first bytes of the frame and the live flags
	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (len_q < LEN_W'(HDR_BYTES)) hdr_q[len_q[2:0]] <= rx_byte;
			alarm_q <= alarm_flags;
			sig_q <= signal_flags;
			end_q <= frame_end;
		end
	end

	// Station address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) station_q <= STATION_RESET;
		else if (cfg_valid && cfg_ready) station_q <= cfg_data;
	end

	// Frame length, overflow, counters and holding registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
			chg_q <= 1'b0;
			rn_q <= '0;
			k_q <= '0;
			i_q <= '0;
			bit_q <= '0;
			for (int r = 0; r < HOLD_REGS; r++) hold_q[r] <= 8'h00;
		end else begin
			unique case (state_q)
				ST_RX: begin
					bit_q <= '0;
					if (in_acc) begin
						if (room) begin
							len_q <= len_q + LEN_W'(1);
						end else if (frame_end) begin
							len_q <= '0;
							ovf_q <= 1'b0;
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_RXCRC, ST_TXCRC: begin
					bit_q <= bit_q + 3'd1;
					if (state_q == ST_TXCRC && bit_q == 3'd7) k_q <= k_q + 7'd1;
				end
				ST_CHECK: begin
					if (!out_valid_q) begin
						len_q <= '0;
						ovf_q <= 1'b0;
						chg_q <= 1'b0;
						k_q <= '0;
						i_q <= '0;
						if (hdr_q[1] == FN_WRITE_ONE || hdr_q[1] == FN_WRITE_MANY)
							rn_q <= 7'd8;
						else
							rn_q <= 7'd5 + {cnt[5:0], 1'b0};
						if (base_ok && hdr_q[1] == FN_WRITE_ONE && w1_ok
							&& start < 16'(HOLD_REGS)) begin
							hold_q[start[2:0]] <= hdr_q[5];
							chg_q <= 1'b1;
						end
					end
				end
				ST_WRRD: begin
				end
				ST_WRUP: begin
					if (a_wr < 17'(HOLD_REGS - 1)) begin
						hold_q[a_wr[2:0]] <= rd_data_q;
						chg_q <= 1'b1;
					end
					i_q <= i_q + 5'd1;
				end
				ST_GEN: begin
					bit_q <= '0;
					if (slot_free && gen_plain) k_q <= k_q + 7'd1;
				end
				default: begin
				end
			endcase
		end
	end

	// Output register: load a reply byte, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_GEN && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_GEN && slot_free) begin
			reply_byte_q <= gen_byte;
			reply_last_q <= last_k;
		end
	end

	assign out_valid = out_valid_q;
	assign reply_byte = reply_byte_q;
	assign reply_last = reply_last_q;
	assign settings_changed = chg_q;
	assign channel_setting = hold_q[0];
	assign sync_setting = hold_q[1];
	assign fan_setting = hold_q[2];
	assign power_setting = hold_q[3];
	assign alarm_temp_setting = hold_q[4];
	assign mode_setting = hold_q[5];
	assign main_switch_setting = hold_q[6];

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(FRAME_BYTES))
		else $error("frame length beyond store");
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (len_q == LEN_W'(FRAME_BYTES)))
		else $error("overflow flagged with room left");
	a_echo_no_crc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TXCRC) |-> (hdr_q[1] != FN_WRITE_ONE))
		else $error("echo reply ran the CRC");
	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GEN && out_valid_q && out_stall) |=> (state_q == ST_GEN))
		else $error("reply advanced over a held result");

endmodule

>>> sv/mrtu_crc_serial.sv
// Bit-serial CRC-16 (reflected polynomial) shared by receive check and reply.
// Depends on mrtu_pkg for the control struct and constants.
module mrtu_crc_serial (
	input  logic               clk,
	input  logic               arst_n,
	input  mrtu_pkg::crc_ctl_t ctl,
	input  logic [7:0]         data_in,
	output logic [15:0]        crc
);
	import mrtu_pkg::*;

	logic [15:0] crc_q;

	// Fold in a byte, then shift one bit per cycle while step is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (ctl.init) begin
			crc_q <= CRC_INIT;
		end else if (ctl.xor_en) begin
			crc_q <= crc_q ^ {8'h00, data_in};
		end else if (ctl.step) begin
			crc_q <= crc_q[0] ? ((crc_q >> 1) ^ CRC_POLY) : (crc_q >> 1);
		end
	end

	assign crc = crc_q;

endmodule
